>>> rtl/ptrr_pkg.sv
package ptrr_pkg;

    // Table size used when the top level is not overridden
    localparam int NUM_SLOTS_DEF = 16;

    // Field widths of the request and result items
    localparam int FUNC_W     = 2;
    localparam int SP_W       = 32;
    localparam int PID_W      = 32;
    localparam int CODE_W     = 32;
    localparam int SLOT_OUT_W = 4;
    localparam int LIVE_OUT_W = 5;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_CREATE = 2'd0;
    localparam logic [FUNC_W-1:0] FN_EXIT   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_YIELD  = 2'd2;
    localparam logic [FUNC_W-1:0] FN_QUERY  = 2'd3;

    // Slot states as stored in the state memory
    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_UNUSED  = 2'd0;
    localparam logic [ST_W-1:0] ST_READY   = 2'd1;
    localparam logic [ST_W-1:0] ST_RUNNING = 2'd2;
    localparam logic [ST_W-1:0] ST_ZOMBIE  = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [SP_W-1:0]          new_task_sp;
        logic [SP_W-1:0]          current_sp;
        logic signed [CODE_W-1:0] exit_status;
    } req_t;

    typedef struct packed {
        logic                  ok;
        logic [SLOT_OUT_W-1:0] new_slot;
        logic [PID_W-1:0]      new_pid;
        logic                  switched;
        logic [SLOT_OUT_W-1:0] prev_slot;
        logic [SLOT_OUT_W-1:0] next_slot;
        logic [SP_W-1:0]       next_sp;
        logic [LIVE_OUT_W-1:0] live_count;
    } resp_t;

endpackage

>>> rtl/ptrr_ram.sv
module ptrr_ram #(
    parameter int WIDTH  = ptrr_pkg::SP_W,
    parameter int DEPTH  = ptrr_pkg::NUM_SLOTS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/process_table_round_robin_core.sv
// Channel | Handshake            | Payload               | Moves
// req     | req_valid/req_stall  | ptrr_pkg::req_t       | one operation request in
// resp    | resp_valid/resp_stall| ptrr_pkg::resp_t      | one result out per request
//
// Create and query pass from acceptance straight to S_DONE; exit and yield go
// through S_SCAN, S_DECIDE and, on a switch, S_SW2, the slot scan reading the
// state memory one entry a cycle. One request is worked on at a time.
// Reset leaves slot 0 running and all other slots unused, with no clearing pass:
// slots at or above the allocation pointer read as unused.
// A result waits in the output register while resp_stall is high; the next
// request is still taken and processed up to the point where its result is due.
module process_table_round_robin_core #(
    parameter int NUM_SLOTS = ptrr_pkg::NUM_SLOTS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  ptrr_pkg::req_t  req_data,
    output logic            resp_valid,
    input  logic            resp_stall,
    output ptrr_pkg::resp_t resp_data
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SW2,
        S_DONE
    } fsm_t;

    // Control state
    fsm_t                      state_reg, state_next;
    logic [SLOT_W-1:0]         cur_reg, cur_next;
    logic                      cur_zombie_reg, cur_zombie_next;
    logic [CNT_W-1:0]          free_reg, free_next;
    logic [ptrr_pkg::PID_W-1:0] next_id_reg, next_id_next;
    logic [CNT_W-1:0]          live_reg, live_next;
    logic                      st0_wr_reg, st0_wr_next;
    logic                      sp0_wr_reg, sp0_wr_next;
    logic                      out_vld_reg, out_vld_next;
    logic                      rvld_reg, rvld_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [SLOT_W-1:0]         iss_reg, iss_next;

    // Payload state
    ptrr_pkg::resp_t           res_reg, res_next;
    ptrr_pkg::resp_t           out_data_reg, out_data_next;
    logic [ptrr_pkg::SP_W-1:0] csp_reg, csp_next;
    logic [SLOT_W-1:0]         nxt_reg, nxt_next;
    logic [ptrr_pkg::ST_W-1:0] nxt_st_reg, nxt_st_next;
    logic [ptrr_pkg::ST_W-1:0] st0_seen_reg, st0_seen_next;
    logic [SLOT_W-1:0]         ridx_reg, ridx_next;
    logic                      rlast_reg, rlast_next;
    logic                      rovr_un_reg, rovr_un_next;
    logic                      rovr_r0_reg, rovr_r0_next;

    // Memory ports
    logic                      st_we;
    logic [SLOT_W-1:0]         st_waddr;
    logic [ptrr_pkg::ST_W-1:0] st_wdata;
    logic [SLOT_W-1:0]         st_raddr;
    logic [ptrr_pkg::ST_W-1:0] st_rdata;
    logic                      sp_we;
    logic [SLOT_W-1:0]         sp_waddr;
    logic [ptrr_pkg::SP_W-1:0] sp_wdata;
    logic [SLOT_W-1:0]         sp_raddr;
    logic [ptrr_pkg::SP_W-1:0] sp_rdata;

    logic [ptrr_pkg::ST_W-1:0] eff_st;
    logic [ptrr_pkg::SP_W-1:0] eff_sp;
    logic [SLOT_W-1:0]         iss_wrap;
    logic [SLOT_W-1:0]         cur_wrap;
    logic [SLOT_W-1:0]         free_idx;

    ptrr_ram #(
        .WIDTH (ptrr_pkg::ST_W),
        .DEPTH (NUM_SLOTS)
    ) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    ptrr_ram #(
        .WIDTH (ptrr_pkg::SP_W),
        .DEPTH (NUM_SLOTS)
    ) u_sp_ram (
        .clk   (clk),
        .we    (sp_we),
        .waddr (sp_waddr),
        .wdata (sp_wdata),
        .raddr (sp_raddr),
        .rdata (sp_rdata)
    );

    // Step slot indexes forward with wrap
    assign iss_wrap = (iss_reg == SLOT_W'(NUM_SLOTS - 1)) ? '0 : SLOT_W'(iss_reg + 1'b1);
    assign cur_wrap = (cur_reg == SLOT_W'(NUM_SLOTS - 1)) ? '0 : SLOT_W'(cur_reg + 1'b1);
    assign free_idx = free_reg[SLOT_W-1:0];

    // Replace never-written entries by their reset value
    assign eff_st = rovr_un_reg ? ptrr_pkg::ST_UNUSED :
                    rovr_r0_reg ? ptrr_pkg::ST_RUNNING : st_rdata;
    assign eff_sp = (((nxt_reg == '0) && !sp0_wr_reg) ||
                     ((nxt_reg != '0) && (CNT_W'(nxt_reg) >= free_reg))) ? '0 : sp_rdata;

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        cur_zombie_next = cur_zombie_reg;
        free_next       = free_reg;
        next_id_next    = next_id_reg;
        live_next       = live_reg;
        st0_wr_next     = st0_wr_reg;
        sp0_wr_next     = sp0_wr_reg;
        out_vld_next    = out_vld_reg;
        cnt_next        = cnt_reg;
        iss_next        = iss_reg;
        res_next        = res_reg;
        out_data_next   = out_data_reg;
        csp_next        = csp_reg;
        nxt_next        = nxt_reg;
        nxt_st_next     = nxt_st_reg;
        st0_seen_next   = st0_seen_reg;

        rvld_next       = 1'b0;
        rlast_next      = 1'b0;
        ridx_next       = iss_reg;
        rovr_un_next    = (iss_reg != '0) && (CNT_W'(iss_reg) >= free_reg);
        rovr_r0_next    = (iss_reg == '0) && !st0_wr_reg;

        st_we    = 1'b0;
        st_waddr = cur_reg;
        st_wdata = ptrr_pkg::ST_READY;
        st_raddr = iss_reg;
        sp_we    = 1'b0;
        sp_waddr = cur_reg;
        sp_wdata = csp_reg;
        sp_raddr = nxt_reg;

        // Drain the output register
        if (out_vld_reg && !resp_stall)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_next.ok        = 1'b1;
                    res_next.new_slot  = '0;
                    res_next.new_pid   = '0;
                    res_next.switched  = 1'b0;
                    res_next.prev_slot = ptrr_pkg::SLOT_OUT_W'(cur_reg);
                    res_next.next_slot = ptrr_pkg::SLOT_OUT_W'(cur_reg);
                    res_next.next_sp   = '0;
                    res_next.live_count = '0;
                    csp_next = req_data.current_sp;
                    iss_next = cur_wrap;
                    cnt_next = '0;
                    case (req_data.func)
                        ptrr_pkg::FN_CREATE:
                        begin
                            // Take the allocation pointer slot if any is left and the new pointer is nonzero
                            if ((free_reg != CNT_W'(NUM_SLOTS)) &&
                                (req_data.new_task_sp != '0))
                            begin
                                st_we    = 1'b1;
                                st_waddr = free_idx;
                                st_wdata = ptrr_pkg::ST_READY;
                                sp_we    = 1'b1;
                                sp_waddr = free_idx;
                                sp_wdata = req_data.new_task_sp;
                                res_next.new_slot = ptrr_pkg::SLOT_OUT_W'(free_idx);
                                res_next.new_pid  = next_id_reg;
                                next_id_next = next_id_reg + 1'b1;
                                free_next    = CNT_W'(free_reg + 1'b1);
                                live_next    = CNT_W'(live_reg + 1'b1);
                            end
                            else
                            begin
                                res_next.ok = 1'b0;
                            end
                            state_next = S_DONE;
                        end
                        ptrr_pkg::FN_EXIT:
                        begin
                            // Mark the current slot as a zombie, then schedule
                            st_we    = 1'b1;
                            st_waddr = cur_reg;
                            st_wdata = ptrr_pkg::ST_ZOMBIE;
                            if (cur_reg == '0)
                            begin
                                st0_wr_next = 1'b1;
                            end
                            if (!cur_zombie_reg)
                            begin
                                live_next = CNT_W'(live_reg - 1'b1);
                            end
                            cur_zombie_next = 1'b1;
                            state_next = S_SCAN;
                        end
                        ptrr_pkg::FN_YIELD:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Issue one state read a cycle, starting after the current slot
                if (cnt_reg != CNT_W'(NUM_SLOTS))
                begin
                    st_raddr   = iss_reg;
                    rvld_next  = 1'b1;
                    rlast_next = (cnt_reg == CNT_W'(NUM_SLOTS - 1));
                    iss_next   = iss_wrap;
                    cnt_next   = CNT_W'(cnt_reg + 1'b1);
                end
                // Check the returning entry
                if (rvld_reg)
                begin
                    if (ridx_reg == '0)
                    begin
                        st0_seen_next = eff_st;
                    end
                    if (eff_st == ptrr_pkg::ST_READY)
                    begin
                        nxt_next    = ridx_reg;
                        nxt_st_next = ptrr_pkg::ST_READY;
                        rvld_next   = 1'b0;
                        state_next  = S_DECIDE;
                    end
                    else if (rlast_reg)
                    begin
                        // No ready slot: fall back to the idle task
                        nxt_next    = '0;
                        nxt_st_next = (ridx_reg == '0) ? eff_st : st0_seen_reg;
                        rvld_next   = 1'b0;
                        state_next  = S_DECIDE;
                    end
                end
            end

            S_DECIDE:
            begin
                if (nxt_reg == cur_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    // Save the outgoing pointer and demote a running task
                    sp_we    = 1'b1;
                    sp_waddr = cur_reg;
                    sp_wdata = csp_reg;
                    if (cur_reg == '0)
                    begin
                        sp0_wr_next = 1'b1;
                    end
                    if (!cur_zombie_reg)
                    begin
                        st_we    = 1'b1;
                        st_waddr = cur_reg;
                        st_wdata = ptrr_pkg::ST_READY;
                        if (cur_reg == '0)
                        begin
                            st0_wr_next = 1'b1;
                        end
                    end
                    sp_raddr = nxt_reg;
                    if ((nxt_st_reg == ptrr_pkg::ST_UNUSED) ||
                        (nxt_st_reg == ptrr_pkg::ST_ZOMBIE))
                    begin
                        live_next = CNT_W'(live_reg + 1'b1);
                    end
                    state_next = S_SW2;
                end
            end

            S_SW2:
            begin
                // Make the next slot running and report its pointer
                st_we    = 1'b1;
                st_waddr = nxt_reg;
                st_wdata = ptrr_pkg::ST_RUNNING;
                if (nxt_reg == '0)
                begin
                    st0_wr_next = 1'b1;
                end
                res_next.switched  = 1'b1;
                res_next.next_slot = ptrr_pkg::SLOT_OUT_W'(nxt_reg);
                res_next.next_sp   = eff_sp;
                cur_next        = nxt_reg;
                cur_zombie_next = 1'b0;
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                // Hand the result over once the output register is free
                if (!out_vld_reg || !resp_stall)
                begin
                    out_vld_next  = 1'b1;
                    out_data_next = res_reg;
                    out_data_next.live_count = ptrr_pkg::LIVE_OUT_W'(live_reg);
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State machine and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_reg        <= '0;
            cur_zombie_reg <= 1'b0;
            free_reg       <= CNT_W'(1);
            next_id_reg    <= ptrr_pkg::PID_W'(1);
            live_reg       <= CNT_W'(1);
            st0_wr_reg     <= 1'b0;
            sp0_wr_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            rvld_reg       <= 1'b0;
            cnt_reg        <= '0;
            iss_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            cur_zombie_reg <= cur_zombie_next;
            free_reg       <= free_next;
            next_id_reg    <= next_id_next;
            live_reg       <= live_next;
            st0_wr_reg     <= st0_wr_next;
            sp0_wr_reg     <= sp0_wr_next;
            out_vld_reg    <= out_vld_next;
            rvld_reg       <= rvld_next;
            cnt_reg        <= cnt_next;
            iss_reg        <= iss_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
        csp_reg      <= csp_next;
        nxt_reg      <= nxt_next;
        nxt_st_reg   <= nxt_st_next;
        st0_seen_reg <= st0_seen_next;
        ridx_reg     <= ridx_next;
        rlast_reg    <= rlast_next;
        rovr_un_reg  <= rovr_un_next;
        rovr_r0_reg  <= rovr_r0_next;
    end

    assign req_stall  = (state_reg != S_IDLE);
    assign resp_valid = out_vld_reg;
    assign resp_data  = out_data_reg;

    // Live tasks never outnumber allocated slots
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= free_reg)
        else $error("live count exceeds allocated slots");

    // The current slot is always the idle task or an allocated slot
    a_cur_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_reg == '0) || (CNT_W'(cur_reg) < free_reg))
        else $error("current slot was never allocated");

    // A switch always moves to a different slot
    a_switch_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SW2) |-> (nxt_reg != cur_reg))
        else $error("switch to the current slot");

    // The resumed pointer comes from a written entry
    a_sp_written: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SW2) |->
            (((nxt_reg == '0) && sp0_wr_reg) || (CNT_W'(nxt_reg) < free_reg)))
        else $error("resumed pointer read from an unwritten entry");

endmodule
